// ===== sv/packet_header_decoder_defines.svh =====
// Assertion macros for the packet header decoder.
// Included by the top level; depends on nothing else.
`ifndef PACKET_HEADER_DECODER_DEFINES_SVH
`define PACKET_HEADER_DECODER_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define PHD_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define PHD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/phd_pkg.sv =====
// Types and constants for the packet header decoder.
// Used by the stream interfaces and the top level; depends on nothing.
package phd_pkg;

  localparam int unsigned HeaderBytes = 6;
  localparam int unsigned CountW      = 17;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 8;

  localparam logic [CountW-1:0] COUNT_MAX    = '1;
  localparam logic [CountW-1:0] HEADER_BYTES = CountW'(HeaderBytes);

  // Header byte positions
  localparam logic [CountW-1:0] POS_MAGIC  = CountW'(0);
  localparam logic [CountW-1:0] POS_TYPE   = CountW'(1);
  localparam logic [CountW-1:0] POS_SEQ_HI = CountW'(2);
  localparam logic [CountW-1:0] POS_SEQ_LO = CountW'(3);
  localparam logic [CountW-1:0] POS_LEN_HI = CountW'(4);
  localparam logic [CountW-1:0] POS_LEN_LO = CountW'(5);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAGIC_VALUE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TYPE    = 1'b1;

  localparam logic [CfgDataW-1:0] MAX_TYPE_RESET = 8'd3;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_MAGIC = 2'd2,
    ST_TYPE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_datagram;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_type;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [1:0]  status;
    logic        end_of_run;
  } out_item_t;

  // One queue entry: the results caused by one accepted item
  typedef struct packed {
    logic        has_pay;
    logic [7:0]  pay;
    logic        has_sum;
    logic [7:0]  typ;
    logic [15:0] seq;
    logic [15:0] len;
    status_e     st;
  } entry_t;

endpackage

// ===== sv/phd_if.sv =====
// Valid/ready stream interfaces for the packet header decoder.
// Depends on phd_pkg for the item types.
interface phd_in_if;
  logic              valid;
  logic              ready;
  phd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface phd_out_if;
  logic               valid;
  logic               ready;
  phd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/packet_header_decoder.sv =====
// Packet header decoder: checks a 6-byte header, forwards payload, emits a summary.
// Each result is written into the result queue when its item is accepted and offered from there.
// Throughput: one byte item per cycle while the result queue is not full; an item that
// closes a datagram while carrying payload yields two results.
// Reset (asynchronous, active low) clears datagram state, queue and registers.
// Depends on phd_pkg, phd_if.sv and packet_header_decoder_defines.svh.
`include "packet_header_decoder_defines.svh"

module packet_header_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [phd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [phd_pkg::CfgDataW-1:0]  cfg_data_i,
  phd_in_if.sink                        in_i,
  phd_out_if.source                     out_o
);

  // Configuration registers
  logic [7:0] magic_q, max_type_q;

  // Datagram state
  logic [phd_pkg::CountW-1:0] cnt_q, cnt_d;
  logic        mag_err_q, mag_err_d;
  logic        typ_err_q, typ_err_d;
  logic [7:0]  typ_q, typ_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] len_q, len_d;

  // Result queue
  phd_pkg::entry_t mem_q [2];
  phd_pkg::entry_t entry;
  phd_pkg::entry_t head;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       phase_q;

  logic accept, push, pop, out_fire, emit_pay;
  logic is_empty, is_last, fwd;
  logic [phd_pkg::CountW-1:0] pay_pos;
  logic [7:0] b;

  assign accept   = in_i.valid && in_i.ready;
  assign b        = in_i.data.data_byte;
  assign is_empty = in_i.data.empty_datagram;
  assign is_last  = in_i.data.last_byte || is_empty;
  assign pay_pos  = cnt_q - phd_pkg::HEADER_BYTES;

  // Forward a payload byte after a good header, up to the stated length
  assign fwd = !is_empty && (cnt_q >= phd_pkg::HEADER_BYTES) && !mag_err_q && !typ_err_q
               && (pay_pos < {1'b0, len_q});

  // Capture header bytes, count the byte, build the summary, clear on last
  always_comb begin
    cnt_d     = cnt_q;
    mag_err_d = mag_err_q;
    typ_err_d = typ_err_q;
    typ_d     = typ_q;
    seq_d     = seq_q;
    len_d     = len_q;
    if (!is_empty) begin
      case (cnt_q)
        phd_pkg::POS_MAGIC:  mag_err_d = (b != magic_q);
        phd_pkg::POS_TYPE: begin
          typ_d     = b;
          typ_err_d = (b > max_type_q);
        end
        phd_pkg::POS_SEQ_HI: seq_d = {b, seq_q[7:0]};
        phd_pkg::POS_SEQ_LO: seq_d = {seq_q[15:8], b};
        phd_pkg::POS_LEN_HI: len_d = {b, len_q[7:0]};
        phd_pkg::POS_LEN_LO: len_d = {len_q[15:8], b};
        default: ;
      endcase
      if (cnt_q != phd_pkg::COUNT_MAX) begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    entry.has_pay = fwd;
    entry.pay     = b;
    entry.has_sum = is_last;
    entry.typ     = typ_d;
    entry.seq     = seq_d;
    entry.len     = len_d;
    if (cnt_d < phd_pkg::HEADER_BYTES) begin
      entry.st = phd_pkg::ST_SIZE;
    end else if (mag_err_d) begin
      entry.st = phd_pkg::ST_MAGIC;
    end else if (typ_err_d) begin
      entry.st = phd_pkg::ST_TYPE;
    end else if (cnt_d != (phd_pkg::HEADER_BYTES + {1'b0, len_d})) begin
      entry.st = phd_pkg::ST_SIZE;
    end else begin
      entry.st = phd_pkg::ST_OK;
    end

    if (is_last) begin
      cnt_d     = '0;
      mag_err_d = 1'b0;
      typ_err_d = 1'b0;
      typ_d     = '0;
      seq_d     = '0;
      len_d     = '0;
    end
  end

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= '0;
      max_type_q <= phd_pkg::MAX_TYPE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        phd_pkg::CFG_MAGIC_VALUE: magic_q    <= cfg_data_i;
        phd_pkg::CFG_MAX_TYPE:    max_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance datagram state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      mag_err_q <= 1'b0;
      typ_err_q <= 1'b0;
      typ_q     <= '0;
      seq_q     <= '0;
      len_q     <= '0;
    end else if (accept) begin
      cnt_q     <= cnt_d;
      mag_err_q <= mag_err_d;
      typ_err_q <= typ_err_d;
      typ_q     <= typ_d;
      seq_q     <= seq_d;
      len_q     <= len_d;
    end
  end

  // Queue control: push items that cause results, pop once fully delivered
  assign push     = accept && (fwd || is_last);
  assign head     = mem_q[rd_ptr_q];
  assign emit_pay = head.has_pay && !phase_q;
  assign out_fire = out_o.valid && out_o.ready;
  assign pop      = out_fire && !(emit_pay && head.has_sum);

  assign in_i.ready  = (count_q != 2'd2);
  assign out_o.valid = (count_q != 2'd0);

  // Present the payload byte first, then the summary
  always_comb begin
    out_o.data = '0;
    if (emit_pay) begin
      out_o.data.result_kind  = phd_pkg::KIND_PAYLOAD;
      out_o.data.payload_byte = head.pay;
    end else begin
      out_o.data.result_kind    = phd_pkg::KIND_SUMMARY;
      out_o.data.packet_type    = head.typ;
      out_o.data.sequence_res   = head.seq;
      out_o.data.payload_length = head.len;
      out_o.data.status         = 2'(head.st);
      out_o.data.end_of_run     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      phase_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
      if (out_fire) begin
        phase_q <= emit_pay && head.has_sum;
      end
    end
  end

  // Store queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  `PHD_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || count_q <= 2'd2,
                     "result queue overfilled")
  `PHD_ASSERT_RST(a_last_clears, clk_i, rst_ni,
                  accept && is_last |=> cnt_q == '0 && !mag_err_q && !typ_err_q,
                  "datagram state not cleared after last item")
  `PHD_ASSERT_RST(a_phase_sum, clk_i, rst_ni,
                  phase_q |-> out_o.valid && head.has_sum && head.has_pay,
                  "summary phase without pending summary")
  `PHD_ASSERT_RST(a_kind_end, clk_i, rst_ni,
                  out_o.valid |-> out_o.data.end_of_run == out_o.data.result_kind,
                  "end flag disagrees with result kind")

endmodule

// ===== tb/tb_packet_header_decoder.sv =====
// Self-checking testbench for packet_header_decoder: drives datagrams byte by byte and checks
// every payload and summary item against a cycle-free model of the header decoding.
// Depends on phd_pkg, phd_if.sv and the packet_header_decoder RTL.
module tb_packet_header_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned EndCycles = 20;
  localparam int unsigned PhaseItems = 270;

  // How a frame built in frame_q is closed
  typedef enum logic [1:0] {
    END_LAST,
    END_MARKER,
    END_OPEN
  } frame_end_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [phd_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [phd_pkg::CfgDataW-1:0] cfg_data_i = '0;

  phd_in_if  in_if ();
  phd_out_if out_if ();

  packet_header_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register copies and per-datagram state of the decoder model
  logic [7:0]                 cfg_magic = 8'h00;
  logic [7:0]                 cfg_max_type = phd_pkg::MAX_TYPE_RESET;
  logic [phd_pkg::CountW-1:0] dg_count = '0;
  logic                       dg_magic_bad = 1'b0;
  logic                       dg_type_bad = 1'b0;
  logic [7:0]                 dg_type = '0;
  logic [15:0]                dg_seq = '0;
  logic [15:0]                dg_len = '0;

  phd_pkg::out_item_t decoded_items [$];
  phd_pkg::out_item_t want;
  logic [7:0]         frame_q [$];
  int unsigned        mismatch_count = 0;
  int unsigned        items_sent = 0;
  int unsigned        quiet_cycles = 0;

  // Idling controls shared by the tests and the two sides
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned rx_hold_request = 0;
  int unsigned rx_stall_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clear the per-datagram state after every summary
  function automatic void clear_datagram();
    dg_count     = '0;
    dg_magic_bad = 1'b0;
    dg_type_bad  = 1'b0;
    dg_type      = '0;
    dg_seq       = '0;
    dg_len       = '0;
  endfunction

  // Decode one accepted byte and queue the payload and summary items it yields
  function automatic void decode_byte(input phd_pkg::in_item_t it);
    phd_pkg::out_item_t res;
    logic               closing;
    int unsigned        pos;
    phd_pkg::status_e   st;
    closing = it.last_byte;
    if (it.empty_datagram) begin
      closing = 1'b1;
    end else begin
      pos = int'(dg_count);
      case (dg_count)
        phd_pkg::POS_MAGIC:  dg_magic_bad = (it.data_byte != cfg_magic);
        phd_pkg::POS_TYPE: begin
          dg_type     = it.data_byte;
          dg_type_bad = (it.data_byte > cfg_max_type);
        end
        phd_pkg::POS_SEQ_HI: dg_seq[15:8] = it.data_byte;
        phd_pkg::POS_SEQ_LO: dg_seq[7:0] = it.data_byte;
        phd_pkg::POS_LEN_HI: dg_len[15:8] = it.data_byte;
        phd_pkg::POS_LEN_LO: dg_len[7:0] = it.data_byte;
        default: begin
          if (!dg_magic_bad && !dg_type_bad && (pos - phd_pkg::HeaderBytes) < dg_len) begin
            res = '0;
            res.result_kind  = phd_pkg::KIND_PAYLOAD;
            res.payload_byte = it.data_byte;
            decoded_items.push_back(res);
          end
        end
      endcase
      if (dg_count != phd_pkg::COUNT_MAX) dg_count = dg_count + 1'b1;
    end
    if (closing) begin
      if (dg_count < phd_pkg::HEADER_BYTES) st = phd_pkg::ST_SIZE;
      else if (dg_magic_bad) st = phd_pkg::ST_MAGIC;
      else if (dg_type_bad) st = phd_pkg::ST_TYPE;
      else if (int'(dg_count) != phd_pkg::HeaderBytes + dg_len) st = phd_pkg::ST_SIZE;
      else st = phd_pkg::ST_OK;
      res = '0;
      res.result_kind    = phd_pkg::KIND_SUMMARY;
      res.packet_type    = dg_type;
      res.sequence_res   = dg_seq;
      res.payload_length = dg_len;
      res.status         = st;
      res.end_of_run     = 1'b1;
      decoded_items.push_back(res);
      clear_datagram();
    end
  endfunction

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
    end
  endtask

  // Compare each output item with the oldest expectation, then decode the input item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (decoded_items.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item: expected none, actual 0x%0h", $time, out_if.data);
        end else begin
          want = decoded_items.pop_front();
          check_field("result_kind", want.result_kind, out_if.data.result_kind);
          check_field("payload_byte", want.payload_byte, out_if.data.payload_byte);
          check_field("packet_type", want.packet_type, out_if.data.packet_type);
          check_field("sequence_res", want.sequence_res, out_if.data.sequence_res);
          check_field("payload_length", want.payload_length, out_if.data.payload_length);
          check_field("status", want.status, out_if.data.status);
          check_field("end_of_run", want.end_of_run, out_if.data.end_of_run);
        end
      end
      if (in_if.valid && in_if.ready) decode_byte(in_if.data);
    end
  end

  // Abort when no item moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side: random stall bursts, plus long holds on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_request != 0) begin
        rx_stall_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (rx_stall_left != 0) begin
        rx_stall_left = rx_stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rx_stall_left = $urandom_range(0, 15);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one item, with an occasional idle burst first, and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic lst, input logic emp);
    phd_pkg::in_item_t it;
    it.data_byte      = b;
    it.last_byte      = lst;
    it.empty_datagram = emp;
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic put_header(input logic [7:0] m, input logic [7:0] t,
                            input logic [15:0] seq, input logic [15:0] len);
    frame_q.push_back(m);
    frame_q.push_back(t);
    frame_q.push_back(seq[15:8]);
    frame_q.push_back(seq[7:0]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
  endtask

  task automatic put_bytes(input int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  // Send the built frame, closed by a last flag, an empty marker or left open
  task automatic send_frame(input frame_end_e how);
    int unsigned i;
    for (i = 0; i < frame_q.size(); i++)
      send_item(frame_q[i], (how == END_LAST) && (i == frame_q.size() - 1), 1'b0);
    if (how == END_MARKER) send_item(8'($urandom), 1'($urandom), 1'b1);
    frame_q.delete();
  endtask

  // Stop offering and wait until every expected item has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (decoded_items.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [phd_pkg::CfgIdxW-1:0] idx,
                           input logic [phd_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == phd_pkg::CFG_MAGIC_VALUE) cfg_magic = val;
    else if (idx == phd_pkg::CFG_MAX_TYPE) cfg_max_type = val;
  endtask

  // One datagram of a randomly chosen shape; most are well formed
  task automatic send_random_datagram();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  m;
    logic [7:0]  t;
    logic [15:0] len;
    kind = $urandom_range(0, 99);
    m    = cfg_magic;
    t    = 8'($urandom_range(0, cfg_max_type));
    len  = 16'($urandom_range(0, 12));
    if ($urandom_range(0, 7) == 0) len = 16'($urandom_range(13, 48));
    if (kind < 62) begin
      put_header(m, t, 16'($urandom), len);
      put_bytes(len);
      send_frame(($urandom_range(0, 9) == 0) ? END_MARKER : END_LAST);
    end else if (kind < 72) begin
      // total size differs from the stated length
      if ($urandom_range(0, 3) == 0) len = 16'($urandom);
      n = $urandom_range(0, 14);
      if (n == len) n++;
      put_header(m, t, 16'($urandom), len);
      put_bytes(n);
      send_frame(END_LAST);
    end else if (kind < 80) begin
      put_header(m ^ 8'($urandom_range(1, 255)), t, 16'($urandom), len);
      put_bytes(len);
      send_frame(END_LAST);
    end else if (kind < 86) begin
      if (cfg_max_type != 8'hFF) t = 8'($urandom_range(cfg_max_type + 1, 255));
      put_header(m, t, 16'($urandom), len);
      put_bytes(len);
      send_frame(END_LAST);
    end else if (kind < 92) begin
      // header cut short
      put_header(m, t, 16'($urandom), 16'($urandom));
      n = $urandom_range(1, 5);
      while (frame_q.size() > n) void'(frame_q.pop_back());
      send_frame(($urandom_range(0, 1) == 0) ? END_MARKER : END_LAST);
    end else if (kind < 95) begin
      send_item(8'($urandom), 1'($urandom), 1'b1);
    end else begin
      put_bytes($urandom_range(1, 10));
      send_frame(($urandom_range(0, 1) == 0) ? END_MARKER : END_LAST);
    end
  endtask

  // Reset register values, payload on the last byte, empty marker, short header
  task automatic test_reset_defaults();
    send_item(8'hFF, 1'b1, 1'b1);
    put_header(8'h00, 8'h03, 16'hFFFF, 16'h0002);
    frame_q.push_back(8'hAA);
    frame_q.push_back(8'h55);
    send_frame(END_LAST);
    put_header(8'h00, 8'h02, 16'h1234, 16'h0000);
    void'(frame_q.pop_back());
    void'(frame_q.pop_back());
    send_frame(END_LAST);
    wait_drained();
  endtask

  // Bad magic, reserved type, excess bytes and a marker closing a datagram early
  task automatic test_header_faults();
    write_reg(phd_pkg::CFG_MAGIC_VALUE, 8'hFF);
    write_reg(phd_pkg::CFG_MAX_TYPE, 8'h00);
    put_header(8'hFE, 8'h00, 16'h0001, 16'h0001);
    frame_q.push_back(8'h77);
    send_frame(END_LAST);
    put_header(8'hFF, 8'h01, 16'h0000, 16'h0000);
    send_frame(END_LAST);
    put_header(8'hFF, 8'h00, 16'h8000, 16'h0000);
    put_bytes(2);
    send_frame(END_LAST);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h56);
    send_frame(END_MARKER);
    wait_drained();
  endtask

  // Random datagrams under one register setting; without idling when calm is set
  task automatic test_random_traffic(input int unsigned n_items, input logic [7:0] m,
                                     input logic [7:0] t, input bit calm);
    int unsigned start;
    write_reg(phd_pkg::CFG_MAGIC_VALUE, m);
    write_reg(phd_pkg::CFG_MAX_TYPE, t);
    tx_idle_en = !calm;
    rx_idle_en = !calm;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if (!calm && $urandom_range(0, 15) == 0) begin
        tx_idle_en = $urandom_range(0, 2) != 0;
        rx_idle_en = $urandom_range(0, 2) != 0;
      end
      send_random_datagram();
    end
    wait_drained();
  endtask

  // Hold the output off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_request = LongHoldCycles;
    repeat (2) begin
      put_header(cfg_magic, 8'h00, 16'($urandom), 16'd24);
      put_bytes(24);
      send_frame(END_LAST);
    end
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold_request = LongHoldCycles;
    repeat (2) begin
      put_header(cfg_magic, 8'h00, 16'($urandom), 16'd20);
      put_bytes(23);
      send_frame(END_LAST);
    end
    wait_drained();
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_header_faults();
    test_random_traffic(PhaseItems, 8'h00, 8'hFF, 1'b0);
    test_random_traffic(PhaseItems, 8'hFF, 8'h00, 1'b0);
    test_random_traffic(PhaseItems, 8'h5A, 8'h07, 1'b0);
    test_backpressure();
    test_random_traffic(PhaseItems, 8'($urandom), 8'($urandom), 1'b0);
    test_random_traffic(PhaseItems, 8'($urandom), 8'($urandom), 1'b1);

    repeat (EndCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
